// ----- rtl/midi_key_pitch_tracker_assert.svh -----
// Assertion macros used by the tracker back end.
`ifndef MIDI_KEY_PITCH_TRACKER_ASSERT_SVH
`define MIDI_KEY_PITCH_TRACKER_ASSERT_SVH

// Check a consequence in the same cycle.
`define MKPT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mkpt assertion failed");

// Check a consequence in the next cycle.
`define MKPT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mkpt assertion failed");

`endif

// ----- rtl/mkpt_pkg.sv -----
// Shared types, constants and table functions of the key pitch tracker.
`default_nettype none
package mkpt_pkg;

	localparam int NUM_KEYS_DEF = 128;

	localparam int PITCH_W = 22;
	localparam int LEVEL_W = 16;
	localparam int TOT_W   = 23;
	localparam int SPL_W   = 44;
	localparam int NUM_W   = 45;
	localparam int CNT_W   = 6;

	localparam logic [7:0] NOTE_ON  = 8'd144;
	localparam logic [7:0] NOTE_OFF = 8'd128;

	localparam logic REG_DECAY = 1'b0;
	localparam logic REG_FLOOR = 1'b1;

	localparam logic [15:0] DECAY_RST = 16'd58982;
	localparam logic [15:0] FLOOR_RST = 16'd328;
	localparam logic [PITCH_W-1:0] PITCH_RST = 22'd112640;
	localparam logic [LEVEL_W-1:0] LEVEL_RST = 16'd8192;

	typedef enum logic [1:0] {
		OP_NOP,
		OP_ON,
		OP_OFF,
		OP_TICK
	} op_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_RD,
		B_MUL,
		B_UPD,
		B_ACC,
		B_DP0,
		B_DP1,
		B_DL0,
		B_DL1
	} bstate_t;

	typedef struct packed {
		op_t          op;
		logic [6:0]   note;
		logic [15:0]  lvl;
	} qent_t;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [TOT_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [NUM_W-1:0] quo;
	} div_rsp_t;

	// round(v * 32768 / 127): v*258 plus a remainder correction of 0..2
	function automatic logic [15:0] vel_level(input logic [6:0] v);
		logic [15:0] q0;
		logic [8:0]  r;
		q0 = 16'(v) * 16'd258;
		r  = 9'({v, 1'b0}) + 9'd63;
		if (r >= 9'd254)
			vel_level = q0 + 16'd2;
		else if (r >= 9'd127)
			vel_level = q0 + 16'd1;
		else
			vel_level = q0;
	endfunction

	function automatic logic [PITCH_W-1:0] pitch_rom(input logic [6:0] n);
		logic [3:0]  oct;
		logic [6:0]  k;
		logic [3:0]  s;
		logic [PITCH_W-1:0] t;
		logic [PITCH_W-1:0] h;
		oct = 4'd0;
		for (int j = 1; j <= 10; j++)
			if (n >= 7'(12 * j))
				oct = oct + 4'd1;
		k = n - 7'(oct) * 7'd12;
		s = 4'd10 - oct;
		unique case (k)
			7'd0:    t = 22'd2143237;
			7'd1:    t = 22'd2270680;
			7'd2:    t = 22'd2405702;
			7'd3:    t = 22'd2548752;
			7'd4:    t = 22'd2700309;
			7'd5:    t = 22'd2860878;
			7'd6:    t = 22'd3030994;
			7'd7:    t = 22'd3211227;
			7'd8:    t = 22'd3402176;
			7'd9:    t = 22'd3604480;
			7'd10:   t = 22'd3818814;
			7'd11:   t = 22'd4045892;
			default: t = '0;
		endcase
		h = (s == 4'd0) ? '0 : (22'd1 << (s - 4'd1));
		pitch_rom = (t + h) >> s;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/mkpt_front.sv -----
// Front end: accepts input words, classifies them and queues commands.
`default_nettype none
module mkpt_front #(
	parameter int NUM_KEYS = mkpt_pkg::NUM_KEYS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	input  wire logic [23:0]     s_tdata,  // status[7:0], note[14:8], velocity[21:15]
	input  wire logic [0:0]      s_tuser,  // cmd[0]
	output logic                 q_valid,
	output mkpt_pkg::qent_t      q_ent,
	input  wire logic            q_pop
);
	import mkpt_pkg::*;

	qent_t      ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	qent_t      cls;
	logic       push;

	always_comb begin
		cls.note = s_tdata[14:8];
		cls.lvl  = vel_level(s_tdata[21:15]);
		priority if (s_tuser[0])
			cls.op = OP_TICK;
		else if ({1'b0, s_tdata[14:8]} >= 8'(NUM_KEYS))
			cls.op = OP_NOP;
		else if (s_tdata[7:0] == NOTE_ON)
			cls.op = OP_ON;
		else if (s_tdata[7:0] == NOTE_OFF)
			cls.op = OP_OFF;
		else
			cls.op = OP_NOP;
	end

	assign s_tready = (cnt_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_ent    = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (q_pop)
				rd_ptr_q <= ~rd_ptr_q;
			unique case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/mkpt_div.sv -----
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module mkpt_div (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire mkpt_pkg::div_req_t req,
	output mkpt_pkg::div_rsp_t    rsp
);
	import mkpt_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [TOT_W-1:0] rem_q;
	logic [TOT_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [TOT_W:0]   r2;
	logic [TOT_W:0]   diff;
	logic             ge;

	assign r2   = {rem_q, quo_q[NUM_W-1]};
	assign diff = r2 - {1'b0, den_q};
	assign ge   = (r2 >= {1'b0, den_q});

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			den_q <= req.den;
			quo_q <= req.num;
		end else if (busy_q) begin
			rem_q <= ge ? diff[TOT_W-1:0] : r2[TOT_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/mkpt_back.sv -----
// Back end: key store, frame walk, result register and configuration.
`default_nettype none
`include "midi_key_pitch_tracker_assert.svh"
module mkpt_back #(
	parameter int NUM_KEYS = mkpt_pkg::NUM_KEYS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_valid,
	input  wire mkpt_pkg::qent_t    q_ent,
	output logic                    q_pop,
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [39:0]             m_tdata,  // pitch[21:0], level[37:22]
	input  wire logic               cfg_we,
	input  wire logic               cfg_idx,
	input  wire logic [15:0]        cfg_data,
	output mkpt_pkg::div_req_t      div_req,
	input  wire mkpt_pkg::div_rsp_t div_rsp
);
	import mkpt_pkg::*;

	localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
	localparam logic [KW-1:0] LAST = KW'(NUM_KEYS - 1);

	bstate_t state_q, state_d;

	logic [15:0]        key_mem [NUM_KEYS];
	logic [NUM_KEYS-1:0] key_vld_q;
	logic [NUM_KEYS-1:0] key_held_q;

	logic [KW-1:0]      idx_q;
	logic [15:0]        decay_q;
	logic [15:0]        floor_q;
	logic [PITCH_W-1:0] cur_pitch_q;
	logic [LEVEL_W-1:0] cur_level_q;
	logic [PITCH_W-1:0] pitch_res_q;
	logic               m_tvalid_q;

	logic [TOT_W-1:0]   total_q;
	logic [TOT_W-1:0]   sum_l_q;
	logic [SPL_W-1:0]   sum_pl_q;
	logic               pl_vld_q;

	logic [15:0]        rdata_s1;
	logic               vld_s1;
	logic [31:0]        prod_s2;
	logic [15:0]        lv_s2;
	logic               held_s2;
	logic [PITCH_W-1:0] pitch_s2;
	logic [37:0]        pl_s3;

	logic               mem_we;
	logic [KW-1:0]      mem_waddr;
	logic [15:0]        mem_wdata;
	logic               mem_re;
	logic [15:0]        lv_rd;
	logic [15:0]        lv_dec;
	logic [15:0]        lv_new;

	assign lv_rd  = vld_s1 ? rdata_s1 : 16'd0;
	assign lv_dec = (prod_s2[31:16] < floor_q) ? 16'd0 : prod_s2[31:16];
	assign lv_new = held_s2 ? lv_s2 : lv_dec;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, cur_level_q, cur_pitch_q};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: if (q_pop && q_ent.op == OP_TICK) state_d = B_RD;
			B_RD:   state_d = B_MUL;
			B_MUL:  state_d = B_UPD;
			B_UPD:  state_d = (idx_q == LAST) ? B_ACC : B_RD;
			B_ACC:  state_d = (total_q == '0) ? B_IDLE : B_DP0;
			B_DP0:  state_d = B_DP1;
			B_DP1:  if (div_rsp.done) state_d = B_DL0;
			B_DL0:  state_d = B_DL1;
			B_DL1:  if (div_rsp.done) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		q_pop         = (state_q == B_IDLE) && q_valid && (!m_tvalid_q || m_tready);
		mem_re        = (state_q == B_RD);
		mem_we        = 1'b0;
		mem_waddr     = idx_q;
		mem_wdata     = lv_new;
		div_req.start = 1'b0;
		div_req.den   = total_q;
		div_req.num   = NUM_W'(sum_pl_q) + NUM_W'(total_q >> 1);
		unique case (state_q)
			B_IDLE: begin
				if (q_pop && q_ent.op == OP_ON) begin
					mem_we    = 1'b1;
					mem_waddr = q_ent.note[KW-1:0];
					mem_wdata = q_ent.lvl;
				end
			end
			B_UPD: mem_we = 1'b1;
			B_DP0: div_req.start = 1'b1;
			B_DL0: begin
				div_req.start = 1'b1;
				div_req.num   = NUM_W'({sum_l_q, 15'd0}) + NUM_W'(total_q >> 1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			key_mem[mem_waddr] <= mem_wdata;
		if (mem_re)
			rdata_s1 <= key_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (state_q == B_RD)
			vld_s1 <= key_vld_q[idx_q];
		if (state_q == B_MUL) begin
			prod_s2  <= 32'(lv_rd) * 32'(decay_q);
			lv_s2    <= lv_rd;
			held_s2  <= key_held_q[idx_q];
			pitch_s2 <= pitch_rom(7'(idx_q));
		end
		if (state_q == B_UPD)
			pl_s3 <= 38'(lv_new) * 38'(pitch_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			key_vld_q   <= '0;
			key_held_q  <= '0;
			idx_q       <= '0;
			decay_q     <= DECAY_RST;
			floor_q     <= FLOOR_RST;
			cur_pitch_q <= PITCH_RST;
			cur_level_q <= LEVEL_RST;
			pitch_res_q <= '0;
			m_tvalid_q  <= 1'b0;
			total_q     <= '0;
			sum_l_q     <= '0;
			sum_pl_q    <= '0;
			pl_vld_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_DECAY: decay_q <= cfg_data;
					REG_FLOOR: floor_q <= cfg_data;
					default: ;
				endcase
			end
			if (mem_we)
				key_vld_q[mem_waddr] <= 1'b1;
			if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;
			// fold the previous key's weighted pitch
			if (pl_vld_q) begin
				sum_pl_q <= sum_pl_q + SPL_W'(pl_s3);
				pl_vld_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (q_pop) begin
						unique case (q_ent.op)
							OP_ON: begin
								key_held_q[q_ent.note[KW-1:0]] <= 1'b1;
								cur_pitch_q <= pitch_rom(q_ent.note);
								cur_level_q <= q_ent.lvl;
								m_tvalid_q  <= 1'b1;
							end
							OP_OFF: begin
								key_held_q[q_ent.note[KW-1:0]] <= 1'b0;
								cur_level_q <= '0;
								m_tvalid_q  <= 1'b1;
							end
							OP_TICK: begin
								idx_q    <= '0;
								total_q  <= '0;
								sum_l_q  <= '0;
								sum_pl_q <= '0;
								pl_vld_q <= 1'b0;
							end
							default: m_tvalid_q <= 1'b1;
						endcase
					end
				end
				B_MUL: total_q <= total_q + TOT_W'(lv_rd);
				B_UPD: begin
					sum_l_q  <= sum_l_q + TOT_W'(lv_new);
					pl_vld_q <= 1'b1;
					if (idx_q != LAST)
						idx_q <= idx_q + KW'(1);
				end
				B_ACC: begin
					if (total_q == '0) begin
						cur_pitch_q <= '0;
						cur_level_q <= '0;
						m_tvalid_q  <= 1'b1;
					end
				end
				B_DP1: if (div_rsp.done) pitch_res_q <= div_rsp.quo[PITCH_W-1:0];
				B_DL1: begin
					if (div_rsp.done) begin
						cur_pitch_q <= pitch_res_q;
						cur_level_q <= div_rsp.quo[LEVEL_W-1:0];
						m_tvalid_q  <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	`MKPT_ASSERT_NOW(a_pop_idle, q_pop, state_q == B_IDLE)
	`MKPT_ASSERT_NOW(a_start_free, div_req.start, !div_rsp.busy)
	`MKPT_ASSERT_NXT(a_tick_done, (state_q == B_DL1) && div_rsp.done, m_tvalid_q)
	`MKPT_ASSERT_NOW(a_walk_quiet, state_q != B_IDLE, !m_tvalid_q)

endmodule
`default_nettype wire

// ----- rtl/midi_key_pitch_tracker.sv -----
// Top level of the MIDI key pitch tracker.
// Input words arrive on s_tvalid/s_tready; s_tuser[0] high marks a frame tick,
// low a MIDI short message (status, note, velocity in s_tdata).
// Every accepted word yields exactly one result word on m_tvalid/m_tready:
// the current pitch (1/256 Hz) and level (Q1.15) after the update.
// Config writes (cfg_we, cfg_idx, cfg_data) set decay factor (0) and floor
// level (1); write them only while the block is idle.
// A front end classifies words into a two-entry command queue; the back end
// executes one command at a time, so input stays open while a result waits.
// A MIDI message is registered in the command queue, then its result in
// the result register; with m_tready high and no tick in progress, messages
// pass at one per cycle. A frame tick walks the key store key by key (read,
// multiply, update) through one memory read port, then runs two divisions
// on one shared divider, or gives zero pitch and level if the total is zero.
// Reset clears all key valid and held marks, so every key level reads as zero,
// sets pitch to 440 Hz and level to 0.25; no clearing pass is needed.
// A stalled receiver holds the result; the queue then fills and s_tready drops.
`default_nettype none
module midi_key_pitch_tracker #(
	parameter int NUM_KEYS = mkpt_pkg::NUM_KEYS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,  // status[7:0], note[14:8], velocity[21:15]
	input  wire logic [0:0]  s_tuser,  // cmd[0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,  // pitch[21:0], level[37:22]
	input  wire logic        cfg_we,
	input  wire logic        cfg_idx,
	input  wire logic [15:0] cfg_data
);
	import mkpt_pkg::*;

	logic     q_valid;
	qent_t    q_ent;
	logic     q_pop;
	div_req_t div_req;
	div_rsp_t div_rsp;

	mkpt_front #(.NUM_KEYS(NUM_KEYS)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_ent    (q_ent),
		.q_pop    (q_pop)
	);

	mkpt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	mkpt_back #(.NUM_KEYS(NUM_KEYS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_ent    (q_ent),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.div_req  (div_req),
		.div_rsp  (div_rsp)
	);

endmodule
`default_nettype wire

// ----- sim/midi_key_pitch_tracker_tb.sv -----
// Self-checking testbench of the MIDI key pitch tracker: predicts each result word.
`default_nettype none
module midi_key_pitch_tracker_tb;
	import mkpt_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;  // status[7:0], note[14:8], velocity[21:15]
	logic [0:0]  s_tuser;  // cmd[0]
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;  // pitch[21:0], level[37:22]
	logic        cfg_we;
	logic        cfg_idx;
	logic [15:0] cfg_data;

	midi_key_pitch_tracker dut (.*);

	localparam int CYCLE_LIMIT = 3_000_000;
	localparam logic [7:0] ST_OTHER = 8'd176;

	// shadow state of the tracker
	logic [15:0] key_lvl [128];
	logic        key_down [128];
	logic [21:0] cur_pitch;
	logic [15:0] cur_level;
	logic [15:0] decay_q16;
	logic [15:0] floor_q15;

	logic [21:0] pitch_due [$];
	logic [15:0] level_due [$];

	int  errors;
	bit  rx_idle_en;
	bit  tx_idle_en;
	int  hold_off;
	int  rx_gap;
	longint cycles;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic logic [21:0] note_pitch(input int n);
		int unsigned oct_tab [12] = '{2143237, 2270680, 2405702, 2548752, 2700309, 2860878,
			3030994, 3211227, 3402176, 3604480, 3818814, 4045892};
		int unsigned s;
		int unsigned h;
		s = 10 - n / 12;
		h = (s == 0) ? 0 : (1 << (s - 1));
		return 22'((oct_tab[n % 12] + h) >> s);
	endfunction

	task automatic track_word(input logic cmd, input logic [7:0] st, input logic [6:0] n,
			input logic [6:0] v);
		longint unsigned total;
		longint unsigned sum_l;
		longint unsigned sum_pl;
		longint unsigned lv;
		total = 0; sum_l = 0; sum_pl = 0;
		if (cmd) begin
			for (int i = 0; i < 128; i++) begin
				lv = key_lvl[i];
				total += lv;
				if (!key_down[i]) begin
					lv = (lv * decay_q16) >> 16;
					if (lv < floor_q15)
						lv = 0;
					key_lvl[i] = 16'(lv);
				end
				sum_l += lv;
				sum_pl += lv * note_pitch(i);
			end
			if (total == 0) begin
				cur_pitch = '0;
				cur_level = '0;
			end else begin
				cur_pitch = 22'((sum_pl + total / 2) / total);
				cur_level = 16'((sum_l * 32768 + total / 2) / total);
			end
		end else if (st == NOTE_ON) begin
			lv = (longint'(v) * 32768 + 63) / 127;
			key_lvl[n] = 16'(lv);
			key_down[n] = 1'b1;
			cur_pitch = note_pitch(n);
			cur_level = 16'(lv);
		end else if (st == NOTE_OFF) begin
			key_down[n] = 1'b0;
			cur_level = '0;
		end
		pitch_due = {pitch_due, cur_pitch};
		level_due = {level_due, cur_level};
	endtask

	task automatic send_word(input logic cmd, input logic [7:0] st, input logic [6:0] n,
			input logic [6:0] v);
		if (tx_idle_en && $urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, 4)) @(negedge clk);
		s_tvalid = 1'b1;
		s_tuser = cmd;
		s_tdata = {2'b00, v, n, st};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		track_word(cmd, st, n, v);
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	// receiver with random stall bursts and an optional long hold-off
	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap <= rx_gap - 1;
			m_tready <= 1'b0;
		end else if (rx_idle_en && m_tready && $urandom_range(0, 3) == 0) begin
			rx_gap <= $urandom_range(0, 3);
			m_tready <= 1'b0;
		end else
			m_tready <= 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pitch_due.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				if (m_tdata[21:0] !== pitch_due[0]) begin
					$error("pitch: expected %0d, got %0d", pitch_due[0], m_tdata[21:0]);
					errors++;
				end
				if (m_tdata[37:22] !== level_due[0]) begin
					$error("level: expected %0d, got %0d", level_due[0], m_tdata[37:22]);
					errors++;
				end
				void'(pitch_due.pop_front());
				void'(level_due.pop_front());
			end
		end
	end

	task automatic drain_results();
		while (pitch_due.size() != 0)
			@(negedge clk);
		repeat (600) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		drain_results();
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_DECAY)
			decay_q16 = val;
		else
			floor_q15 = val;
	endtask

	task automatic send_midi_msg();
		int r;
		r = $urandom_range(0, 9);
		send_word(1'b0, (r < 5) ? NOTE_ON : (r < 9) ? NOTE_OFF : 8'($urandom),
			7'($urandom), 7'($urandom));
	endtask

	task automatic test_directed();
		send_word(1'b1, 8'h00, 7'd0, 7'd0);           // tick with zero total
		send_word(1'b0, NOTE_ON, 7'd0, 7'd127);
		send_word(1'b0, NOTE_ON, 7'd127, 7'd1);
		send_word(1'b0, NOTE_ON, 7'd69, 7'd0);        // velocity zero
		send_word(1'b0, NOTE_ON, 7'd60, 7'd64);
		send_word(1'b0, ST_OTHER, 7'd10, 7'd100);     // ignored status
		send_word(1'b0, 8'hFF, 7'h7F, 7'h7F);
		send_word(1'b1, 8'hFF, 7'h7F, 7'h7F);         // held keys, fields ignored
		send_word(1'b0, NOTE_OFF, 7'd0, 7'd55);
		send_word(1'b0, NOTE_OFF, 7'd127, 7'd0);
		repeat (4) send_word(1'b1, 8'h00, 7'd0, 7'd0);
		send_word(1'b0, NOTE_OFF, 7'd60, 7'd0);
		send_word(1'b0, NOTE_OFF, 7'd69, 7'd0);
		repeat (3) send_word(1'b1, 8'h5A, 7'h2A, 7'h55);
	endtask

	task automatic test_config_sweep();
		logic [15:0] dec_set [4] = '{16'd0, 16'd65535, 16'd32768, 16'd58982};
		logic [15:0] flr_set [4] = '{16'd32768, 16'd0, 16'd1000, 16'd328};
		for (int k = 0; k < 4; k++) begin
			write_reg(REG_DECAY, dec_set[k]);
			write_reg(REG_FLOOR, flr_set[k]);
			repeat (40) begin
				if ($urandom_range(0, 4) == 0)
					send_word(1'b1, 8'($urandom), 7'($urandom), 7'($urandom));
				else
					send_midi_msg();
			end
		end
	endtask

	task automatic test_backpressure();
		hold_off = 200;
		repeat (8) send_midi_msg();
		send_word(1'b1, 8'd0, 7'd0, 7'd0);
	endtask

	task automatic test_random();
		for (int i = 0; i < 1250; i++) begin
			if (i == 1050) begin
				tx_idle_en = 0;
				rx_idle_en = 0;
			end
			if ($urandom_range(0, 7) == 0)
				send_word(1'b1, 8'($urandom), 7'($urandom), 7'($urandom));
			else
				send_midi_msg();
		end
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		hold_off = 0;
		rx_gap = 0;
		rx_idle_en = 1;
		tx_idle_en = 1;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = 1'b0;
		cfg_data = '0;
		for (int i = 0; i < 128; i++) begin
			key_lvl[i] = '0;
			key_down[i] = 1'b0;
		end
		cur_pitch = PITCH_RST;
		cur_level = LEVEL_RST;
		decay_q16 = DECAY_RST;
		floor_q15 = FLOOR_RST;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_backpressure();
		test_config_sweep();
		test_random();
		drain_results();
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
`default_nettype wire
